FILE: sv/abcg_pkg.sv
`default_nettype none

package abcg_pkg;

  // elapsed-time counter width
  localparam int TIMER_BITS = 16;

  // field widths
  localparam int PH_W    = 11;
  localparam int TEMP_W  = 12;
  localparam int TICKS_W = 16;
  localparam int LEVEL_W = 2;

  // configuration register map (index = byte address / 4)
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PH_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PH_HIGH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE      = 3'd4;

  // reset values of the configuration registers
  localparam logic [PH_W-1:0]    PH_LOW_RST     = 11'd600;
  localparam logic [PH_W-1:0]    PH_HIGH_RST    = 11'd800;
  localparam logic [TEMP_W-1:0]  TEMP_LIMIT_RST = 12'd300;
  localparam logic [TICKS_W-1:0] PULSE_RST      = 16'd100;
  localparam logic [TICKS_W-1:0] CYCLE_RST      = 16'd1000;

  // alert level codes
  localparam logic [LEVEL_W-1:0] LEVEL_NONE = 2'd0;

  typedef logic [TIMER_BITS-1:0] timer_t;

  typedef struct packed {
    logic [PH_W-1:0]    ph_low_limit;
    logic [PH_W-1:0]    ph_high_limit;
    logic [TEMP_W-1:0]  temp_alert_limit;
    logic [TICKS_W-1:0] pulse_ticks;
    logic [TICKS_W-1:0] cycle_ticks;
  } abcg_cfg_t;

  // one tick moving into the blink sequencer
  typedef struct packed {
    logic               fire;
    logic [LEVEL_W-1:0] level;
  } abcg_step_t;

  // result of one tick
  typedef struct packed {
    logic               led_lit;
    logic [LEVEL_W-1:0] alert_level;
  } abcg_res_t;

endpackage

`default_nettype wire

FILE: sv/abcg_classify.sv
`default_nettype none

module abcg_classify
  import abcg_pkg::*;
(
  input  wire abcg_cfg_t          cfg,
  input  wire logic [PH_W-1:0]    ph_reading,
  input  wire logic [TEMP_W-1:0]  temp_reading,
  output logic      [LEVEL_W-1:0] level
);

  logic ph_bad;
  logic temp_bad;

  // window check on ph, signed limit check on temperature
  always_comb begin
    ph_bad   = (ph_reading < cfg.ph_low_limit) || (ph_reading > cfg.ph_high_limit);
    temp_bad = $signed(temp_reading) > $signed(cfg.temp_alert_limit);
    level    = {temp_bad, ph_bad};
  end

endmodule

`default_nettype wire

FILE: sv/abcg_blink.sv
`default_nettype none

module abcg_blink
  import abcg_pkg::*;
(
  input  wire             clk,
  input  wire             rst_n,
  input  wire abcg_cfg_t  cfg,
  input  wire abcg_step_t step,
  output abcg_res_t       res
);

  localparam timer_t TIMER_MAX = '1;

  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               lamp_r, lamp_nxt;
  logic [LEVEL_W-1:0] pulses_r, pulses_nxt;
  timer_t             toggle_r, toggle_nxt;
  timer_t             cycle_r, cycle_nxt;
  logic               toggle_due;
  logic               cycle_due;

  // state registers, updated once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= LEVEL_NONE;
      lamp_r   <= 1'b0;
      pulses_r <= '0;
      toggle_r <= '0;
      cycle_r  <= '0;
    end else if (step.fire) begin
      level_r  <= level_nxt;
      lamp_r   <= lamp_nxt;
      pulses_r <= pulses_nxt;
      toggle_r <= toggle_nxt;
      cycle_r  <= cycle_nxt;
    end
  end

  // saturating advance, level change restart, then blink sequencing
  always_comb begin
    level_nxt  = level_r;
    lamp_nxt   = lamp_r;
    pulses_nxt = pulses_r;
    toggle_nxt = (toggle_r == TIMER_MAX) ? TIMER_MAX : toggle_r + 1'b1;
    cycle_nxt  = (cycle_r == TIMER_MAX) ? TIMER_MAX : cycle_r + 1'b1;

    if (step.level != level_r) begin
      level_nxt  = step.level;
      lamp_nxt   = 1'b0;
      pulses_nxt = '0;
      toggle_nxt = '0;
      cycle_nxt  = '0;
    end

    toggle_due = 33'(toggle_nxt) >= 33'(cfg.pulse_ticks);
    cycle_due  = 33'(cycle_nxt) >= 33'(cfg.cycle_ticks);

    if (level_nxt != LEVEL_NONE) begin
      if (lamp_nxt) begin
        if (toggle_due) begin
          lamp_nxt   = 1'b0;
          toggle_nxt = '0;
        end
      end else if (pulses_nxt < level_nxt) begin
        if (toggle_due) begin
          lamp_nxt   = 1'b1;
          pulses_nxt = pulses_nxt + 1'b1;
          toggle_nxt = '0;
        end
      end else if (cycle_due) begin
        pulses_nxt = '0;
        cycle_nxt  = '0;
      end
    end else begin
      lamp_nxt = 1'b0;
    end

    res.led_lit     = lamp_nxt;
    res.alert_level = level_nxt;
  end

endmodule

`default_nettype wire

FILE: sv/alert_blink_code_generator_top.sv
// path: each accepted input beat is held in the input register, then its result in the result register
// throughput: one tick per cycle while the result side takes beats; each tick updates the blink state in one pass
//   between the input register and the result register
// backpressure on the result side stalls both registers in place
// reset: synchronous active-low rst_n clears state, empties both registers and
//   restores the configuration registers to their defaults
`default_nettype none

module alert_blink_code_generator_top
  import abcg_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  // input stream
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  wire  [23:0]            in_tdata,     // ph_reading[10:0], temp_reading[22:11], pad
  // result stream
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [7:0]             out_tdata,    // led_lit[0], alert_level[2:1], pad
  // configuration
  input  wire                    cfg_psel,
  input  wire                    cfg_penable,
  input  wire                    cfg_pwrite,
  input  wire  [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire  [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  abcg_cfg_t          cfg_r;
  logic               cfg_wr;
  logic [CFG_IDX_W-1:0] cfg_idx;

  logic               in_valid_r;
  logic [PH_W-1:0]    in_ph_r;
  logic [TEMP_W-1:0]  in_temp_r;

  logic               out_valid_r;
  abcg_res_t          out_res_r;

  logic               out_free;
  logic               fire;
  logic [LEVEL_W-1:0] level;
  abcg_step_t         step;
  abcg_res_t          res;

  // configuration register file
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ph_low_limit     <= PH_LOW_RST;
      cfg_r.ph_high_limit    <= PH_HIGH_RST;
      cfg_r.temp_alert_limit <= TEMP_LIMIT_RST;
      cfg_r.pulse_ticks      <= PULSE_RST;
      cfg_r.cycle_ticks      <= CYCLE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PH_LOW:     cfg_r.ph_low_limit     <= cfg_pwdata[PH_W-1:0];
        REG_PH_HIGH:    cfg_r.ph_high_limit    <= cfg_pwdata[PH_W-1:0];
        REG_TEMP_LIMIT: cfg_r.temp_alert_limit <= cfg_pwdata[TEMP_W-1:0];
        REG_PULSE:      cfg_r.pulse_ticks      <= cfg_pwdata[TICKS_W-1:0];
        REG_CYCLE:      cfg_r.cycle_ticks      <= cfg_pwdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (cfg_idx)
      REG_PH_LOW:     cfg_prdata = 32'(cfg_r.ph_low_limit);
      REG_PH_HIGH:    cfg_prdata = 32'(cfg_r.ph_high_limit);
      REG_TEMP_LIMIT: cfg_prdata = 32'(cfg_r.temp_alert_limit);
      REG_PULSE:      cfg_prdata = 32'(cfg_r.pulse_ticks);
      REG_CYCLE:      cfg_prdata = 32'(cfg_r.cycle_ticks);
      default:        cfg_prdata = '0;
    endcase
  end

  // handshake: a tick moves on when the result register is free or draining
  assign out_free  = !out_valid_r || out_tready;
  assign fire      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_ph_r   <= in_tdata[PH_W-1:0];
      in_temp_r <= in_tdata[PH_W+TEMP_W-1:PH_W];
    end
  end

  // classification and blink sequencing
  abcg_classify u_classify (
    .cfg          (cfg_r),
    .ph_reading   (in_ph_r),
    .temp_reading (in_temp_r),
    .level        (level)
  );

  assign step = {fire, level};

  abcg_blink u_blink (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .step  (step),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_res_r.alert_level, out_res_r.led_lit};

endmodule

`default_nettype wire

FILE: sv/abcg_checker.sv
`default_nettype none

module abcg_props
  import abcg_pkg::*;
(
  input wire                   clk,
  input wire                   rst_n,
  input wire                   out_tvalid,
  input wire                   out_tready,
  input wire [7:0]             out_tdata,
  input wire                   cfg_pready
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // led only lit with an active alert level
  a_led_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[2:1] != LEVEL_NONE)
    else $error("led lit with no alert");

  // pad bits of a result beat stay zero
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:3] == 5'd0)
    else $error("result pad bits set");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("cfg_pready low");

endmodule

bind alert_blink_code_generator_top abcg_props u_abcg_props (.*);

`default_nettype wire

FILE: sim/abcg_checker.sv
`timescale 1ns / 1ps

module abcg_checker
  import abcg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [23:0]           in_tdata,     // ph_reading[10:0], temp_reading[22:11], pad
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [7:0]            out_tdata,    // led_lit[0], alert_level[2:1], pad
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    fail_count,
  output int                    pending
);

  // shadow of the configuration registers
  abcg_cfg_t lim;

  // shadow of the blink sequencer
  logic [LEVEL_W-1:0] level_q;
  logic               lamp_q;
  logic [1:0]         burst_q;
  timer_t             toggle_age;
  timer_t             cycle_age;

  // led codes still owed by the block, oldest first
  abcg_res_t led_code_q[$];
  abcg_res_t want;
  abcg_res_t got;
  int        errs = 0;
  int        beat_n = 0;

  function automatic timer_t sat_inc(timer_t t);
    return (t == '1) ? t : t + 1'b1;
  endfunction

  function void flag_error(string msg);
    if (errs < 10) $display("%0t: result beat %0d: %s", $time, beat_n, msg);
    errs++;
  endfunction

  // advance the sequencer by one tick and return the led code it shows
  function automatic abcg_res_t blink_tick(logic [PH_W-1:0] ph, logic [TEMP_W-1:0] temp);
    logic               ph_bad;
    logic               temp_bad;
    logic [LEVEL_W-1:0] lvl;
    abcg_res_t          r;
    ph_bad   = (ph < lim.ph_low_limit) || (ph > lim.ph_high_limit);
    temp_bad = $signed(temp) > $signed(lim.temp_alert_limit);
    lvl      = {temp_bad, ph_bad};
    toggle_age = sat_inc(toggle_age);
    cycle_age  = sat_inc(cycle_age);
    // a new level restarts the burst from dark
    if (lvl != level_q) begin
      level_q    = lvl;
      lamp_q     = 1'b0;
      burst_q    = '0;
      toggle_age = '0;
      cycle_age  = '0;
    end
    if (level_q != LEVEL_NONE) begin
      if (lamp_q) begin
        if (toggle_age >= lim.pulse_ticks) begin
          lamp_q     = 1'b0;
          toggle_age = '0;
        end
      end else if (burst_q < level_q) begin
        if (toggle_age >= lim.pulse_ticks) begin
          lamp_q     = 1'b1;
          burst_q    = burst_q + 2'd1;
          toggle_age = '0;
        end
      end else if (cycle_age >= lim.cycle_ticks) begin
        burst_q   = '0;
        cycle_age = '0;
      end
    end else begin
      lamp_q = 1'b0;
    end
    r.led_lit     = lamp_q;
    r.alert_level = level_q;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      lim.ph_low_limit     = PH_LOW_RST;
      lim.ph_high_limit    = PH_HIGH_RST;
      lim.temp_alert_limit = TEMP_LIMIT_RST;
      lim.pulse_ticks      = PULSE_RST;
      lim.cycle_ticks      = CYCLE_RST;
      level_q    = LEVEL_NONE;
      lamp_q     = 1'b0;
      burst_q    = '0;
      toggle_age = '0;
      cycle_age  = '0;
      led_code_q.delete();
    end else begin
      // result beat against the oldest owed code
      if (out_tvalid && out_tready) begin
        if (led_code_q.size() == 0) begin
          flag_error($sformatf("unexpected beat, data %0h", out_tdata));
        end else begin
          want = led_code_q.pop_front();
          got.led_lit     = out_tdata[0];
          got.alert_level = out_tdata[2:1];
          if (got.led_lit !== want.led_lit)
            flag_error($sformatf("led_lit expected %0d got %0d", want.led_lit, got.led_lit));
          if (got.alert_level !== want.alert_level)
            flag_error($sformatf("alert_level expected %0d got %0d",
                                 want.alert_level, got.alert_level));
        end
        beat_n++;
      end
      // tick beat
      if (in_tvalid && in_tready)
        led_code_q.push_back(blink_tick(in_tdata[PH_W-1:0], in_tdata[PH_W+TEMP_W-1:PH_W]));
      // register write
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_ADDR_W-1:2])
          REG_PH_LOW:     lim.ph_low_limit     = cfg_pwdata[PH_W-1:0];
          REG_PH_HIGH:    lim.ph_high_limit    = cfg_pwdata[PH_W-1:0];
          REG_TEMP_LIMIT: lim.temp_alert_limit = cfg_pwdata[TEMP_W-1:0];
          REG_PULSE:      lim.pulse_ticks      = cfg_pwdata[TICKS_W-1:0];
          REG_CYCLE:      lim.cycle_ticks      = cfg_pwdata[TICKS_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count <= errs;
    pending    <= led_code_q.size();
  end

endmodule

FILE: sim/alert_blink_code_generator_top_tb.sv
`timescale 1ns / 1ps

module alert_blink_code_generator_top_tb;
  import abcg_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000000;
  // address past the register list, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata = '0;     // ph_reading[10:0], temp_reading[22:11], pad
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;         // led_lit[0], alert_level[2:1], pad
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  int fail_count;
  int pending;
  int cycles = 0;
  int hold_left = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  bit calm = 1'b0;

  // current limits, used only to aim readings at the window edges
  logic [PH_W-1:0]   cur_low = PH_LOW_RST;
  logic [PH_W-1:0]   cur_high = PH_HIGH_RST;
  logic [TEMP_W-1:0] cur_temp = TEMP_LIMIT_RST;

  alert_blink_code_generator_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  abcg_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == WATCHDOG_CYCLES) begin
      $display("alert_blink_code_generator_top_tb: FAIL");
      $finish;
    end
  end

  // result side: random stalls, quiet stretches, and a counted hold-off
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= 300;
      hold_done  <= 1'b1;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 25);
    end
  end

  // one tick beat, then maybe a short idle gap
  task automatic send_tick(logic [PH_W-1:0] ph, logic [TEMP_W-1:0] temp);
    in_tdata  <= {1'b0, temp, ph};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  // register write: setup, access, then idle before returning
  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // hold the ticks until every owed result is out
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic setup_phase(int low, int high, int tlim, int pulse, int cycle);
    wait_idle();
    cfg_put(REG_PH_LOW, low);
    cfg_put(REG_PH_HIGH, high);
    cfg_put(REG_TEMP_LIMIT, tlim);
    cfg_put(REG_PULSE, pulse);
    cfg_put(REG_CYCLE, cycle);
    cur_low  = PH_W'(low);
    cur_high = PH_W'(high);
    cur_temp = TEMP_W'(tlim);
  endtask

  function automatic logic [PH_W-1:0] pick_ph();
    case ($urandom_range(0, 5))
      0: return PH_W'($urandom_range(0, 2047));
      1: return cur_low - 1'b1;
      2: return cur_low;
      3: return cur_high;
      4: return cur_high + 1'b1;
      default: return PH_W'($urandom_range(0, 1400));
    endcase
  endfunction

  function automatic logic [TEMP_W-1:0] pick_temp();
    case ($urandom_range(0, 4))
      0: return TEMP_W'($urandom_range(0, 4095));
      1: return cur_temp - 1'b1;
      2: return cur_temp;
      3: return cur_temp + 1'b1;
      default: return TEMP_W'(int'($urandom_range(0, 1800)) - 550);
    endcase
  endfunction

  // runs of steady readings so bursts play out, with short noisy runs between
  task automatic run_random(int n);
    int sent;
    int len;
    logic [PH_W-1:0]   ph;
    logic [TEMP_W-1:0] temp;
    sent = 0;
    while (sent < n) begin
      ph   = pick_ph();
      temp = pick_temp();
      len  = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 2) : $urandom_range(3, 70);
      repeat (len) send_tick(ph, temp);
      sent += len;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes and window edges at the default limits
    send_tick(11'd0, 12'd0);
    send_tick(11'd2047, 12'd0);
    send_tick(11'd599, 12'd0);
    send_tick(11'd600, 12'd0);
    send_tick(11'd800, 12'd0);
    send_tick(11'd801, 12'd0);
    send_tick(11'd700, 12'd300);
    send_tick(11'd700, 12'd301);
    send_tick(11'd700, -12'sd550);
    send_tick(11'd700, 12'h800);
    send_tick(11'd700, 12'h7FF);
    send_tick(11'd700, 12'd1250);
    send_tick(11'd0, 12'h7FF);
    send_tick(11'd1400, 12'd1250);
    send_tick(11'd700, 12'hFFF);
    send_tick(11'd2047, 12'h800);
    send_tick(11'd2047, 12'h800);
    send_tick(11'd700, 12'd0);

    // zero pulse and cycle lengths, window 0 to 1400, temp limit -550
    setup_phase(0, 1400, -550, 0, 0);
    cfg_put(REG_SPARE, 32'hFFFF_FFFF);
    run_random(150);

    // inverted window, one-tick pulses, no idling on either side
    setup_phase(900, 500, 1250, 1, 1);
    calm = 1'b1;
    run_random(150);
    calm = 1'b0;

    // window limits at the ends of the reading range, temp limit at both encodings' ends,
    // and a long result-side hold-off while ticks keep coming
    setup_phase(2047, 0, -2048, 2, 5);
    hold_go = 1'b1;
    run_random(150);
    setup_phase(0, 2047, 2047, 3, 12);
    run_random(100);

    // random limits with short pulses and cycles
    for (int k = 0; k < 5; k++) begin
      setup_phase($urandom_range(0, 1400), $urandom_range(0, 1400),
                  int'($urandom_range(0, 1800)) - 550,
                  $urandom_range(0, 6), $urandom_range(0, 40));
      run_random(200);
    end

    // longest pulse and cycle
    setup_phase(600, 800, 300, 65535, 65535);
    run_random(100);

    // drain and settle
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("alert_blink_code_generator_top_tb: PASS");
    end else begin
      $display("alert_blink_code_generator_top_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: alert_blink_code_generator_top.f
sv/abcg_pkg.sv
sv/abcg_classify.sv
sv/abcg_blink.sv
sv/alert_blink_code_generator_top.sv
sv/abcg_checker.sv
sim/abcg_checker.sv
sim/alert_blink_code_generator_top_tb.sv
